// ===== design/mpat_pkg.sv =====
// Shared types, codes and constants for the memory port access timing block.
package mpat_pkg;

  localparam int MAX_BYTE_COUNT = 65535;

  localparam int DELAY_W  = 4;
  localparam int CYCLE_W  = 22;
  localparam int BYTES_W  = 16;
  localparam int PORT_W   = 32;

  // Port register layout
  localparam int WR_DELAY_LO   = 0;
  localparam int RD_DELAY_LO   = 4;
  localparam int USE_RECOVERY  = 8;
  localparam int USE_HOLD      = 9;
  localparam int USE_FLOAT     = 10;
  localparam int USE_STROBE    = 11;
  localparam int BUS_16BIT     = 12;
  localparam int DMA_DELAY_LO  = 24;
  localparam int DMA_DELAY_SEL = 29;
  localparam int DMA_BUS_32BIT = 30;

  // Timing offsets
  localparam int FIRST_FLOOR   = 6;
  localparam int DELAY_EXTRA   = 2;
  localparam int FIRST_MIN_ADD = 6;
  localparam int SEQ_MIN_ADD   = 2;

  typedef enum logic [1:0] {
    CMD_WRITE_PORT = 2'd0,
    CMD_READ_PORT  = 2'd1,
    CMD_QUERY      = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_RECOVERY = 2'd0,
    REG_HOLD     = 2'd1,
    REG_FLOAT    = 2'd2,
    REG_STROBE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [PORT_W-1:0]  write_data;
    logic               is_write;
    logic               is_dma;
    logic [BYTES_W-1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [PORT_W-1:0]  read_data;
    logic [CYCLE_W-1:0] access_cycles;
  } out_item_t;

  typedef struct packed {
    logic [DELAY_W-1:0] recovery;
    logic [DELAY_W-1:0] hold;
    logic [DELAY_W-1:0] float_dly;
    logic [DELAY_W-1:0] strobe;
  } common_delays_t;

endpackage

// ===== design/mpat_timing.sv =====
// Bus cycle count of one access from the port setting and the common delays.
module mpat_timing
  import mpat_pkg::*;
(
  input  logic [PORT_W-1:0]  setting,
  input  common_delays_t     delays,
  input  logic               is_write,
  input  logic               is_dma,
  input  logic [BYTES_W-1:0] byte_count,
  output logic [CYCLE_W-1:0] access_cycles
);

  logic signed [7:0]    base;
  logic signed [7:0]    delay;
  logic signed [7:0]    minimum;
  logic signed [7:0]    first;
  logic signed [7:0]    seq;
  logic [BYTES_W-1:0]   bytes;
  logic [BYTES_W:0]     accesses;
  logic [BYTES_W-1:0]   more;
  logic [CYCLE_W:0]     total;

  always_comb begin
    if (is_dma && setting[DMA_DELAY_SEL]) begin
      delay = $signed({4'b0000, setting[DMA_DELAY_LO +: DELAY_W]});
    end else if (is_write) begin
      delay = $signed({4'b0000, setting[WR_DELAY_LO +: DELAY_W]});
    end else begin
      delay = $signed({4'b0000, setting[RD_DELAY_LO +: DELAY_W]});
    end

    minimum = setting[USE_STROBE] ? $signed({4'b0000, delays.strobe}) : 8'sd0;

    // recovery of zero drives the sum to minus one
    base = 8'sd0;
    if (setting[USE_RECOVERY]) begin
      base = base + $signed({4'b0000, delays.recovery}) - 8'sd1;
    end
    if (setting[USE_FLOAT]) begin
      base = base + $signed({4'b0000, delays.float_dly});
    end
    if (is_write && setting[USE_HOLD]) begin
      base = base + $signed({4'b0000, delays.hold});
    end

    first = base + delay + 8'(DELAY_EXTRA);
    if (base < 8'(FIRST_FLOOR)) begin
      first = first + 8'sd1;
    end
    seq = base + delay + 8'(DELAY_EXTRA);
    if (first < minimum + 8'(FIRST_MIN_ADD)) begin
      first = minimum + 8'(FIRST_MIN_ADD);
    end
    if (seq < minimum + 8'(SEQ_MIN_ADD)) begin
      seq = minimum + 8'(SEQ_MIN_ADD);
    end

    bytes = (32'(byte_count) > 32'(MAX_BYTE_COUNT)) ? BYTES_W'(MAX_BYTE_COUNT) : byte_count;

    if (bytes == '0) begin
      accesses = (BYTES_W+1)'(1);
    end else if (is_dma && setting[DMA_BUS_32BIT]) begin
      accesses = ({1'b0, bytes} + (BYTES_W+1)'(3)) >> 2;
    end else if (setting[BUS_16BIT]) begin
      accesses = ({1'b0, bytes} + (BYTES_W+1)'(1)) >> 1;
    end else begin
      accesses = {1'b0, bytes};
    end
    more = BYTES_W'(accesses - (BYTES_W+1)'(1));

    // first and seq are always positive and below 64
    total = (CYCLE_W+1)'(first[5:0]) + (CYCLE_W+1)'(seq[5:0]) * (CYCLE_W+1)'(more);
    access_cycles = total[CYCLE_W-1:0];
  end

endmodule

// ===== design/memory_port_access_timing.sv =====
// Top level: port register, pending countdown, common delays and result register.
//
// One item is accepted per clock cycle while in_ready is high; its result
// is registered in the next cycle; the block takes the next item in the same cycle a
// waiting result is taken. Throughput is set by the single result register:
// in_ready is low only while a result is held and out_ready is low. Port
// register writes (cmd 0) save the old setting as the active one unless a
// change is pending, and arm a two-query countdown during which timing queries
// use the active setting. Common delays are written through cfg_we/cfg_index.
module memory_port_access_timing
  import mpat_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  reg_idx_t         cfg_index,
  input  logic [DELAY_W-1:0] cfg_data
);

  logic [PORT_W-1:0]  port_setting;
  logic [PORT_W-1:0]  active_setting;
  logic [1:0]         pending_count;
  common_delays_t     delays;
  logic               accept;
  logic [CYCLE_W-1:0] cycles;
  out_item_t          out_item_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  mpat_timing u_timing (
    .setting       ((pending_count != 2'd0) ? active_setting : port_setting),
    .delays        (delays),
    .is_write      (in_item.is_write),
    .is_dma        (in_item.is_dma),
    .byte_count    (in_item.byte_count),
    .access_cycles (cycles)
  );

  always_comb begin
    out_item_next = '0;
    case (in_item.cmd)
      CMD_READ_PORT: out_item_next.read_data = port_setting;
      CMD_QUERY:     out_item_next.access_cycles = cycles;
      default:       out_item_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delays <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RECOVERY: delays.recovery  <= cfg_data;
        REG_HOLD:     delays.hold      <= cfg_data;
        REG_FLOAT:    delays.float_dly <= cfg_data;
        REG_STROBE:   delays.strobe    <= cfg_data;
        default:      delays           <= delays;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_setting   <= '0;
      active_setting <= '0;
      pending_count  <= '0;
    end else if (accept) begin
      case (in_item.cmd)
        CMD_WRITE_PORT: begin
          if (pending_count == 2'd0) begin
            active_setting <= port_setting;
          end
          pending_count <= 2'd2;
          port_setting  <= in_item.write_data;
        end
        CMD_QUERY: begin
          // count down; release the new setting when it expires
          if (pending_count != 2'd0) begin
            pending_count <= pending_count - 2'd1;
            if (pending_count == 2'd1) begin
              active_setting <= port_setting;
            end
          end
        end
        default: begin
          pending_count <= pending_count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= out_item_next;
    end
  end

endmodule

// ===== design/mpat_checker.sv =====
// Port-level checks for the memory port access timing block, bound to the top level.
module mpat_checker
  import mpat_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with result register empty");

  a_item_yields_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  a_query_no_data: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.cmd != CMD_READ_PORT |=> out_item.read_data == '0)
    else $error("read data set for a non-read item");

  a_cycles_only_query: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.cmd != CMD_QUERY |=> out_item.access_cycles == '0)
    else $error("cycle count set for a non-query item");

endmodule

bind memory_port_access_timing mpat_checker u_mpat_checker (.*);
